FILE: src/fixed_block_pool_allocator_assert.svh
// Assertion macros for the block pool allocator.
// FBPA_ASSERT checks a property while reset is released.
// FBPA_ASSERT_ALWAYS checks a property on every rising clock edge.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FBPA_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FBPA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FBPA_ASSERT(name, clk, rstn, prop, msg)
`define FBPA_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: src/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int COUNT_W   = 9;
  localparam int BYTES_W   = 24;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  // reset values of the configuration registers
  localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = '0;
  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST   = 16'd64;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST  = 9'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] block_address_in;
  } fbpa_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address_out;
    logic [BYTES_W-1:0]  bytes_allocated;
    logic                can_allocate;
  } fbpa_out_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: src/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: hands out blocks of block_size bytes from a pool of
// block_count blocks starting at base_address, keeping free blocks on a LIFO list held in a
// link memory (one entry per block: next index plus an end-of-list bit). One request is in
// work at a time; in_stall_o is high while it is. An allocate passes through a link memory
// read, an index times size multiply and a base add before its result is ready. A deallocate
// waits on the restoring divider that turns the pool offset into a block index one bit per
// cycle (32 steps). A clear rewrites every link entry, one per cycle. After reset the
// same rewrite runs before the first request is taken; configuration writes are taken
// at any time.
`default_nettype none

`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_wdata_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fbpa_pkg::fbpa_in_t                 in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fbpa_pkg::fbpa_out_t                out_data_o
);

  import fbpa_pkg::*;

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int LINK_W = IDX_W + 1;
  localparam int PROD_W = IDX_W + SIZE_W;
  localparam int RST_LAST =
    ((int'(BLOCK_COUNT_RST) > NUM_BLOCKS) ? NUM_BLOCKS : int'(BLOCK_COUNT_RST)) - 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  // sequencer states
  localparam logic [2:0] ST_SWEEP = 3'd0;  // rebuild the free list
  localparam logic [2:0] ST_IDLE  = 3'd1;  // wait for a request
  localparam logic [2:0] ST_ALLOC = 3'd2;  // pop head, multiply index by size
  localparam logic [2:0] ST_ADD   = 3'd3;  // add base to the product
  localparam logic [2:0] ST_DIV   = 3'd4;  // wait for the divider, push
  localparam logic [2:0] ST_DONE  = 3'd5;  // hand the result to the output register

  logic [2:0]          state_q, state_d;

  // configuration registers
  logic [ADDR_W-1:0]   base_q;
  logic [SIZE_W-1:0]   size_q;
  logic [COUNT_W-1:0]  count_q;

  // free list head and byte count
  logic [IDX_W-1:0]    head_q, head_d;
  logic                head_valid_q, head_valid_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;

  // list rebuild
  logic [IDX_W-1:0]    sweep_idx_q, sweep_idx_d;
  logic [IDX_W-1:0]    sweep_last_q, sweep_last_d;
  logic                sweep_reply_q, sweep_reply_d;

  // working and result registers
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic                out_valid_q, out_valid_d;
  fbpa_out_t           out_q, out_d;

  // effective size and count
  logic [SIZE_W-1:0]   eff_size;
  logic [CNT_W-1:0]    eff_count;
  logic [IDX_W-1:0]    eff_last;
  logic [BYTES_W:0]    bytes_sum;
  logic                out_free;
  logic                in_xfer;

  // link memory
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [LINK_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [LINK_W-1:0]   ram_rdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign eff_size = (size_q == '0) ? SIZE_W'(1) : size_q;

  always_comb begin
    if (count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(count_q) > 32'(NUM_BLOCKS)) begin
      eff_count = CNT_W'(NUM_BLOCKS);
    end else begin
      eff_count = CNT_W'(count_q);
    end
  end

  assign eff_last  = IDX_W'(eff_count - CNT_W'(1));
  assign bytes_sum = {1'b0, bytes_q} + (BYTES_W + 1)'(eff_size);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_xfer   = in_valid_i && (state_q == ST_IDLE);

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_ADDRESS_RST;
      size_q  <= BLOCK_SIZE_RST;
      count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_ADDRESS: base_q  <= cfg_wdata_i;
        CFG_BLOCK_SIZE:   size_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_BLOCK_COUNT:  count_q <= cfg_wdata_i[COUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    head_valid_d  = head_valid_q;
    bytes_d       = bytes_q;
    sweep_idx_d   = sweep_idx_q;
    sweep_last_d  = sweep_last_q;
    sweep_reply_d = sweep_reply_q;
    prod_d        = prod_q;
    res_status_d  = res_status_q;
    res_addr_d    = res_addr_q;
    out_d         = out_q;
    // drop the valid once the result has been transferred
    out_valid_d   = out_valid_q && out_stall_i;

    ram_we        = 1'b0;
    ram_waddr     = sweep_idx_q;
    ram_wdata     = '0;
    ram_re        = 1'b0;

    div_req.start    = 1'b0;
    div_req.dividend = in_data_i.block_address_in - base_q;
    div_req.divisor  = eff_size;

    unique case (state_q)
      ST_SWEEP: begin
        // entry i links to i+1 (wrapping), the end bit is set from the last block in use onwards
        ram_we    = 1'b1;
        ram_waddr = sweep_idx_q;
        ram_wdata = {sweep_idx_q >= sweep_last_q,
                     (sweep_idx_q == LAST_IDX) ? IDX_W'(0) : sweep_idx_q + IDX_W'(1)};
        if (sweep_idx_q == LAST_IDX) begin
          sweep_idx_d   = '0;
          sweep_reply_d = 1'b0;
          state_d       = sweep_reply_q ? ST_DONE : ST_IDLE;
        end else begin
          sweep_idx_d = sweep_idx_q + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d = STATUS_OK;
          res_addr_d   = '0;
          case (in_data_i.kind)
            KIND_ALLOC: begin
              if (!head_valid_q) begin
                res_status_d = STATUS_EMPTY;
                state_d      = ST_DONE;
              end else begin
                ram_re  = 1'b1;
                state_d = ST_ALLOC;
              end
            end
            KIND_DEALLOC: begin
              if (in_data_i.block_address_in < base_q) begin
                res_status_d = STATUS_OUTSIDE;
                state_d      = ST_DONE;
              end else begin
                div_req.start = 1'b1;
                state_d       = ST_DIV;
              end
            end
            KIND_CLEAR: begin
              // latch the count now; later register writes do not touch the rebuild
              sweep_last_d  = eff_last;
              sweep_reply_d = 1'b1;
              sweep_idx_d   = '0;
              head_d        = '0;
              head_valid_d  = 1'b1;
              bytes_d       = '0;
              state_d       = ST_SWEEP;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        // the link of the old head is on the memory output now
        prod_d = PROD_W'(head_q) * PROD_W'(eff_size);
        if (ram_rdata[LINK_W-1]) begin
          head_valid_d = 1'b0;
        end else begin
          head_d = ram_rdata[IDX_W-1:0];
        end
        bytes_d = (bytes_sum > (BYTES_W + 1)'(BYTES_MAX)) ? BYTES_MAX
                                                          : bytes_sum[BYTES_W-1:0];
        state_d = ST_ADD;
      end
      ST_ADD: begin
        // address wraps modulo 2^32
        res_addr_d = base_q + ADDR_W'(prod_q);
        state_d    = ST_DONE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient < ADDR_W'(eff_count)) begin
            // push the block: it links to the old head
            ram_we       = 1'b1;
            ram_waddr    = div_rsp.quotient[IDX_W-1:0];
            ram_wdata    = {!head_valid_q, head_q};
            head_d       = div_rsp.quotient[IDX_W-1:0];
            head_valid_d = 1'b1;
            bytes_d      = (bytes_q >= BYTES_W'(eff_size)) ? bytes_q - BYTES_W'(eff_size)
                                                           : '0;
          end else begin
            res_status_d = STATUS_OUTSIDE;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.status            = res_status_q;
          out_d.block_address_out = res_addr_q;
          out_d.bytes_allocated   = bytes_q;
          out_d.can_allocate      = head_valid_q;
          out_valid_d             = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      head_q        <= '0;
      head_valid_q  <= 1'b1;
      bytes_q       <= '0;
      sweep_idx_q   <= '0;
      sweep_last_q  <= IDX_W'(RST_LAST);
      sweep_reply_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      head_valid_q  <= head_valid_d;
      bytes_q       <= bytes_d;
      sweep_idx_q   <= sweep_idx_d;
      sweep_last_q  <= sweep_last_d;
      sweep_reply_q <= sweep_reply_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_q        <= out_d;
  end

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  fbpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a new result only ever comes out of the hand-off state
  `FBPA_ASSERT(a_out_from_done, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE, "result raised outside hand-off")
  // divider finishes only while the sequencer waits for it
  `FBPA_ASSERT(a_div_done_in_div, clk_i, rst_ni,
    div_rsp.done |-> state_q == ST_DIV, "divider finished with no deallocate pending")
  // the link memory is never read and written in one cycle
  `FBPA_ASSERT(a_ram_one_port, clk_i, rst_ni,
    !(ram_we && ram_re), "link memory read and write collide")
  // a request transfer starts work, so the next cycle is busy
  `FBPA_ASSERT(a_busy_after_xfer, clk_i, rst_ni,
    in_xfer |=> in_stall_o, "request taken without leaving idle")

endmodule

`default_nettype wire

FILE: src/fbpa_ram.sv
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/fbpa_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module fbpa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbpa_pkg::div_req_t  req_i,
  output fbpa_pkg::div_rsp_t  rsp_o
);

  import fbpa_pkg::*;

  localparam int STEPS = ADDR_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] dvs_q, dvs_d;
  logic [ADDR_W-1:0] quo_q, quo_d;
  logic [SIZE_W:0]   rem_shift;
  logic [SIZE_W:0]   rem_diff;

  // shift in the next dividend bit and try the subtract
  assign rem_shift = {rem_q, quo_q[ADDR_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(STEPS);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, dvs_q}) begin
        rem_d = rem_diff[SIZE_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[SIZE_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;
  import fbpa_pkg::*;

  localparam int POOL_BLOCKS = 256;

  // codes the package leaves unnamed: the spare request kind and register index
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  // settle time after the last result: longer than a clear
  localparam int TAIL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  logic      req_valid = 1'b0;
  logic      req_stall;
  fbpa_in_t  req_data = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  fbpa_out_t rsp_data;

  fixed_block_pool_allocator #(
    .NUM_BLOCKS(POOL_BLOCKS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_data_i  (req_data),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_data_o (rsp_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pool mirror: register copies plus the free list, updated on every transfer
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  cfg_base  = BASE_ADDRESS_RST;
  logic [SIZE_W-1:0]  cfg_size  = BLOCK_SIZE_RST;
  logic [COUNT_W-1:0] cfg_count = BLOCK_COUNT_RST;

  int unsigned        link_next [POOL_BLOCKS];
  bit                 link_last [POOL_BLOCKS];
  int unsigned        head;
  bit                 head_ok;
  logic [BYTES_W-1:0] bytes_out;

  fbpa_out_t owed_results [$];
  int unsigned fail_count = 0;

  // a zero count acts as one block, anything past the pool bound as the bound
  function automatic int unsigned live_count();
    if (cfg_count == 0) return 1;
    if (cfg_count > POOL_BLOCKS) return POOL_BLOCKS;
    return cfg_count;
  endfunction

  // a zero block size acts as one byte
  function automatic logic [31:0] live_size();
    return (cfg_size == 0) ? 32'd1 : 32'(cfg_size);
  endfunction

  // chain block i to i+1 (wrapping), with the end mark on every block from count-1 up
  function automatic void relink_pool();
    int unsigned n;
    n = live_count();
    for (int unsigned i = 0; i < POOL_BLOCKS; i++) begin
      link_next[i] = (i + 1) % POOL_BLOCKS;
      link_last[i] = (i + 1 >= n);
    end
    head      = 0;
    head_ok   = 1'b1;
    bytes_out = '0;
  endfunction

  function automatic fbpa_out_t pool_response(fbpa_in_t req);
    fbpa_out_t   rsp;
    logic [31:0] bs;
    logic [31:0] idx;
    logic [31:0] sum;
    bit          in_pool;
    rsp = '0;
    bs  = live_size();
    case (req.kind)
      KIND_ALLOC: begin
        if (!head_ok) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          rsp.block_address_out = cfg_base + head * bs;
          if (link_last[head]) head_ok = 1'b0;
          else head = link_next[head];
          sum = 32'(bytes_out) + bs;
          bytes_out = (sum > 32'(BYTES_MAX)) ? BYTES_MAX : sum[BYTES_W-1:0];
        end
      end
      KIND_DEALLOC: begin
        // truncating divide: any byte inside a block frees that block
        in_pool = (req.block_address_in >= cfg_base);
        idx = '0;
        if (in_pool) begin
          idx = (req.block_address_in - cfg_base) / bs;
          in_pool = (idx < live_count());
        end
        if (!in_pool) begin
          rsp.status = STATUS_OUTSIDE;
        end else begin
          // push even on a double free; the list may then loop on itself
          link_next[idx] = head;
          link_last[idx] = !head_ok;
          head      = idx;
          head_ok   = 1'b1;
          bytes_out = (32'(bytes_out) >= bs) ? bytes_out - bs[BYTES_W-1:0] : '0;
        end
      end
      KIND_CLEAR: relink_pool();
      default: ;
    endcase
    rsp.bytes_allocated = bytes_out;
    rsp.can_allocate    = head_ok;
    return rsp;
  endfunction

  initial relink_pool();

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly short gaps, a few long ones, and calm stretches
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_span(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(999);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if (r < 5) begin
      calm = $urandom_range(300, 80);
      return 0;
    end
    if (r < 550) return 0;
    if (r < 900) return $urandom_range(3, 1);
    if (r < 980) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: pending queue filled by the stimulus block below
  // ---------------------------------------------------------------------------
  typedef struct {
    fbpa_in_t req;
    bit       wait_drain;  // hold back until every owed result is in
  } pend_t;

  pend_t       pend_q [$];
  bit          req_taken = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;

  // sample the request transfer and predict its result
  always @(posedge clk) begin
    req_taken = rst_n && req_valid && !req_stall;
    if (req_taken) owed_results.push_back(pool_response(req_data));
  end

  // change request inputs on the falling edge only; hold a stalled payload
  always @(negedge clk) begin
    if (rst_n && (!req_valid || req_taken)) begin
      if (send_gap != 0) begin
        req_valid <= 1'b0;
        send_gap--;
      end else if (pend_q.size() != 0 &&
                   !(pend_q[0].wait_drain && owed_results.size() != 0)) begin
        req_data  <= pend_q[0].req;
        req_valid <= 1'b1;
        pend_q.pop_front();
        send_gap = idle_span(send_calm);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, then compare against the oldest owed one
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;

  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
      if ($urandom_range(2) == 0) stall_left = idle_span(stall_calm);
    end
  end

  always @(posedge clk) begin : check_results
    fbpa_out_t want;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d addr %h bytes %0d can %0b",
                   rsp_data.status, rsp_data.block_address_out,
                   rsp_data.bytes_allocated, rsp_data.can_allocate);
      end else begin
        want = owed_results.pop_front();
        if (rsp_data.status !== want.status ||
            rsp_data.block_address_out !== want.block_address_out ||
            rsp_data.bytes_allocated !== want.bytes_allocated ||
            rsp_data.can_allocate !== want.can_allocate) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: want status %0d addr %h bytes %0d can %0b, got status %0d addr %h bytes %0d can %0b",
                     want.status, want.block_address_out, want.bytes_allocated,
                     want.can_allocate, rsp_data.status, rsp_data.block_address_out,
                     rsp_data.bytes_allocated, rsp_data.can_allocate);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int unsigned req_total = 0;
  int unsigned gen_free [$];  // free list as the generator expects it, head first
  int unsigned gen_used [$];

  task automatic queue_req(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                           input bit hold = 1'b0);
    pend_t p;
    p.req.kind             = kind;
    p.req.block_address_in = addr;
    p.wait_drain           = hold;
    pend_q.push_back(p);
    if (kind != KIND_UNUSED) req_total++;
  endtask

  // write one register while the block is idle, and track it in the mirror
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BASE_ADDRESS: cfg_base  = val;
      CFG_BLOCK_SIZE:   cfg_size  = val[SIZE_W-1:0];
      CFG_BLOCK_COUNT:  cfg_count = val[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until everything queued has been sent and answered
  task automatic drain();
    do @(negedge clk);
    while (pend_q.size() != 0 || req_valid || owed_results.size() != 0);
  endtask

  // address of byte off inside block idx, wrapping at 32 bits
  function automatic logic [ADDR_W-1:0] spot(int unsigned idx, logic [31:0] off);
    return cfg_base + idx * live_size() + off;
  endfunction

  function automatic logic [31:0] any_offset();
    return $urandom_range(live_size() - 1, 0);
  endfunction

  // items that leave the pool state alone: spare kind or just past the pool end
  task automatic queue_harmless();
    if ($urandom_range(1) == 0) queue_req(KIND_UNUSED, $urandom);
    else queue_req(KIND_DEALLOC, spot(live_count(), any_offset()));
  endtask

  task automatic queue_noise();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) queue_req(KIND_ALLOC, $urandom);
    else if (r < 50) queue_req(KIND_DEALLOC, $urandom);
    else if (r < 75) queue_req(KIND_DEALLOC, spot($urandom_range(live_count() + 1, 0), any_offset()));
    else if (r < 85) queue_req(KIND_DEALLOC, cfg_base - $urandom_range(4, 1));
    else if (r < 95) queue_req(KIND_UNUSED, $urandom);
    else if (r < 98) queue_req(KIND_DEALLOC, spot($urandom_range(live_count() - 1, 0), 0), 1'b1);
    else queue_req(KIND_CLEAR, $urandom);
  endtask

  // clear, then a legal mix of allocates and frees of held blocks, then a
  // short broken tail; now and then only noise on a list left as it was
  task automatic queue_sequence();
    int unsigned n;
    int unsigned len;
    int unsigned pick;
    int unsigned idx;
    n = live_count();
    if ($urandom_range(99) < 85) begin
      queue_req(KIND_CLEAR, $urandom);
      gen_free.delete();
      gen_used.delete();
      for (int unsigned k = 0; k < n; k++) gen_free.push_back(k);
      len = $urandom_range((n * 3 > 64) ? 70 : n * 3 + 6, 6);
      repeat (len) begin
        if ($urandom_range(9) == 0) begin
          queue_harmless();
        end else if (gen_used.size() == 0 || $urandom_range(99) < 55) begin
          if (gen_free.size() != 0) gen_used.push_back(gen_free.pop_front());
          queue_req(KIND_ALLOC, $urandom);
        end else begin
          pick = $urandom_range(gen_used.size() - 1, 0);
          idx  = gen_used[pick];
          gen_used.delete(pick);
          gen_free.push_front(idx);
          queue_req(KIND_DEALLOC, spot(idx, any_offset()));
        end
      end
      repeat ($urandom_range(3, 0)) queue_noise();
    end else begin
      repeat ($urandom_range(20, 5)) queue_noise();
    end
  endtask

  task automatic pick_settings(input int unsigned round);
    int unsigned r;
    logic [31:0] upper;
    upper = $urandom;
    case (round)
      0: begin
        write_reg(CFG_BASE_ADDRESS, 32'h0000_0000);
        write_reg(CFG_BLOCK_SIZE, {upper[31:16], 16'd1});
        write_reg(CFG_BLOCK_COUNT, {upper[31:9], 9'd1});
      end
      1: begin
        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_BLOCK_SIZE, 32'h0000_FFFF);
        write_reg(CFG_BLOCK_COUNT, 32'd256);
      end
      2: begin
        write_reg(CFG_BASE_ADDRESS, 32'h0010_0000);
        write_reg(CFG_BLOCK_SIZE, 32'h0000_FFFF);
        write_reg(CFG_BLOCK_COUNT, 32'd256);
      end
      3: begin
        write_reg(CFG_BASE_ADDRESS, $urandom);
        write_reg(CFG_BLOCK_SIZE, {upper[31:16], 16'd0});
        write_reg(CFG_BLOCK_COUNT, {upper[31:9], 9'd0});
      end
      4: begin
        write_reg(CFG_BASE_ADDRESS, 32'h0000_0000);
        write_reg(CFG_BLOCK_SIZE, 32'd16);
        write_reg(CFG_BLOCK_COUNT, 32'd511);
      end
      default: begin
        if ($urandom_range(3) != 0) begin
          r = $urandom_range(99);
          if (r < 15) write_reg(CFG_BASE_ADDRESS, 32'h0);
          else if (r < 25) write_reg(CFG_BASE_ADDRESS, $urandom);
          else write_reg(CFG_BASE_ADDRESS, $urandom_range(32'hFF00_0000, 0));
        end
        if ($urandom_range(3) != 0) begin
          r = $urandom_range(99);
          if (r < 10) write_reg(CFG_BLOCK_SIZE, {upper[31:16], 16'd0});
          else if (r < 20) write_reg(CFG_BLOCK_SIZE, {upper[31:16], 16'hFFFF});
          else if (r < 35) write_reg(CFG_BLOCK_SIZE, {upper[31:16], 16'($urandom_range(65535, 1))});
          else write_reg(CFG_BLOCK_SIZE, {upper[31:16], 16'($urandom_range(300, 1))});
        end
        if ($urandom_range(3) != 0) begin
          r = $urandom_range(99);
          if (r < 10) write_reg(CFG_BLOCK_COUNT, {upper[31:9], 9'd0});
          else if (r < 20) write_reg(CFG_BLOCK_COUNT, {upper[31:9], 9'd256});
          else if (r < 30) write_reg(CFG_BLOCK_COUNT, {upper[31:9], 9'($urandom_range(511, 257))});
          else if (r < 40) write_reg(CFG_BLOCK_COUNT, {upper[31:9], 9'($urandom_range(256, 1))});
          else write_reg(CFG_BLOCK_COUNT, {upper[31:9], 9'($urandom_range(24, 1))});
        end
        if ($urandom_range(9) < 3) write_reg(CFG_UNUSED, $urandom);
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned round;
    int unsigned budget;

    // hold reset, then release it away from the rising edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, 64-byte blocks from address 0
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_ALLOC, 32'hFFFF_FFFF);
    queue_req(KIND_DEALLOC, 32'd127);            // last byte of block 1
    queue_req(KIND_DEALLOC, 32'd64);             // same block again
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);                // double free hands it out twice
    queue_req(KIND_DEALLOC, 32'hFFFF_FFFF);
    queue_req(KIND_DEALLOC, 32'd16384);          // one past the last block
    queue_req(KIND_DEALLOC, 32'd16383);          // last byte of the last block
    queue_req(KIND_UNUSED, 32'hFFFF_FFFF);
    queue_req(KIND_UNUSED, 32'h0);
    queue_req(KIND_CLEAR, 32'h0);
    queue_req(KIND_DEALLOC, 32'h0);              // byte count floors at zero
    drain();

    // zero size and zero count act as one; spare register index is ignored
    write_reg(CFG_BASE_ADDRESS, 32'h0000_1000);
    write_reg(CFG_BLOCK_SIZE, 32'hFFFF_0000);
    write_reg(CFG_BLOCK_COUNT, 32'hFFFF_FE00);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_req(KIND_CLEAR, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);                // list exhausted
    queue_req(KIND_DEALLOC, 32'h0000_0FFF);      // below the base
    queue_req(KIND_DEALLOC, 32'h0000_1001);
    queue_req(KIND_DEALLOC, 32'h0000_1000);
    drain();

    // top base, widest blocks, count above the bound: addresses wrap
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFF0);
    write_reg(CFG_BLOCK_SIZE, 32'h0000_FFFF);
    write_reg(CFG_BLOCK_COUNT, 32'd511);
    queue_req(KIND_CLEAR, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_DEALLOC, 32'h0000_FFEF);
    queue_req(KIND_DEALLOC, 32'hFFFF_FFFF);

    // random rounds, each under its own register settings
    req_total = 0;
    round = 0;
    while (req_total < 1950) begin
      drain();
      pick_settings(round);
      if (round == 2) begin
        // loop the list on one block and allocate until the byte count saturates
        queue_req(KIND_CLEAR, $urandom, 1'b1);
        queue_req(KIND_ALLOC, $urandom);
        queue_req(KIND_DEALLOC, cfg_base);
        queue_req(KIND_DEALLOC, cfg_base);
        repeat (258) queue_req(KIND_ALLOC, $urandom);
        queue_req(KIND_DEALLOC, cfg_base + 32'd17);
      end
      budget = req_total + $urandom_range(200, 60);
      while (req_total < budget) queue_sequence();
      round++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // guard against a hang: far beyond the slowest legal run
  initial begin
    #40000000;
    $display("tb failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/fbpa_pkg.sv
src/fbpa_ram.sv
src/fbpa_div.sv
src/fixed_block_pool_allocator.sv
dv/tb.sv
